### rtl/chtr_pkg.sv
// Shared types and constants for the channel trace record FIFO.
// Depends on nothing; chtr_ram and the top level in rtl/ use it.
`default_nettype none

package chtr_pkg;

    localparam int QUEUE_BYTES_DEF = 1024;
    localparam int NUM_CHANNELS    = 16;
    localparam int BYTE_W          = 8;
    localparam int MASK_W          = 16;
    localparam int MAX_LEN         = 251;
    localparam int REC_OVERHEAD    = 6;
    localparam int MAX_RECORDS     = 255;
    localparam int LEN_BIAS        = 4;

    // Request type codes.
    localparam logic [2:0] REQ_TICK    = 3'd0;
    localparam logic [2:0] REQ_HEADER  = 3'd1;
    localparam logic [2:0] REQ_PAYLOAD = 3'd2;
    localparam logic [2:0] REQ_READ    = 3'd3;
    localparam logic [2:0] REQ_FLUSH   = 3'd4;

    // Header byte positions.
    localparam logic [2:0] HDR_CHAN  = 3'd0;
    localparam logic [2:0] HDR_LEN   = 3'd1;
    localparam logic [2:0] HDR_TS0   = 3'd2;
    localparam logic [2:0] HDR_TS1   = 3'd3;
    localparam logic [2:0] HDR_TS2   = 3'd4;
    localparam logic [2:0] HDR_TS3   = 3'd5;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_CHAN_OFF = 3'd1,
        ST_NO_SPACE = 3'd2,
        ST_TOO_LONG = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_NO_FIT   = 3'd5
    } chtr_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_HDR,
        S_RDLEN,
        S_RDBYTE,
        S_HOLD
    } chtr_state_t;

endpackage

`default_nettype wire

### rtl/chtr_cfg_if.sv
// Configuration write channel of the channel trace record FIFO.
// Stands alone; carries the channel enable mask.
`default_nettype none

interface chtr_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] chan_mask;

    modport source (output valid, output chan_mask, input ready);
    modport sink   (input valid, input chan_mask, output ready);
endinterface

`default_nettype wire

### rtl/chtr_req_if.sv
// Request channel of the channel trace record FIFO.
// Stands alone; carries one request per handshake.
`default_nettype none

interface chtr_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [3:0]  channel;
    logic [7:0]  length;
    logic [7:0]  data_byte;
    logic [11:0] room;

    modport source (output valid, output req_type, output channel, output length,
                    output data_byte, output room, input ready);
    modport sink   (input valid, input req_type, input channel, input length,
                    input data_byte, input room, output ready);
endinterface

`default_nettype wire

### rtl/chtr_rsp_if.sv
// Response channel of the channel trace record FIFO.
// Stands alone; carries one response per request.
`default_nettype none

interface chtr_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       record_last;
    logic [7:0] records_ready;

    modport source (output valid, output status, output out_byte, output byte_valid,
                    output record_last, output records_ready, input ready);
    modport sink   (input valid, input status, input out_byte, input byte_valid,
                    input record_last, input records_ready, output ready);
endinterface

`default_nettype wire

### rtl/chtr_ram.sv
// Byte queue storage: one write port, one read port with registered data.
// Depends on chtr_pkg for the default depth and the byte width.
`default_nettype none

module chtr_ram #(
    parameter int  DEPTH = chtr_pkg::QUEUE_BYTES_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [chtr_pkg::BYTE_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [chtr_pkg::BYTE_W-1:0] rd_data
);

    logic [chtr_pkg::BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/channel_trace_record_fifo.sv
// Top level of the channel trace record FIFO: control sequencer and result register.
// Depends on chtr_pkg, chtr_cfg_if, chtr_req_if, chtr_rsp_if and chtr_ram.
//
//   Channel  Direction  Moves
//   cfg      in         chan_mask write, always ready
//   req      in         one request: tick, header, payload, read or flush
//   rsp      out        one response per request: status, byte, flags, record count
//
// A request is taken only while the sequencer is idle. Tick, flush, payload and refused
// headers finish in S_EXEC; an accepted header goes on to S_HDR, where its six bytes go
// one per cycle through the single memory write port. A byte is read out in S_RDBYTE; at a
// record start S_RDLEN comes first, for the length fetched through the one read port.
// Reset clears pointers, counters, the timestamp and the mask; the memory is not cleared.
// A response that the sink does not take is parked, and the sequencer waits for it.
`default_nettype none

module channel_trace_record_fifo #(
    parameter int QUEUE_BYTES = chtr_pkg::QUEUE_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    chtr_cfg_if.sink           cfg,
    chtr_req_if.sink           req,
    chtr_rsp_if.source         rsp
);

    import chtr_pkg::*;

    localparam int PW = $clog2(QUEUE_BYTES);
    localparam int FW = $clog2(QUEUE_BYTES + 1);
    localparam int SW = FW + 1;

    chtr_state_t state_reg, state_next;

    // Latched request.
    logic [2:0]  req_type_reg;
    logic [3:0]  chan_reg;
    logic [7:0]  len_reg;
    logic [7:0]  data_reg;
    logic [11:0] room_reg;

    // Queue bookkeeping.
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [7:0]    rec_count_reg, rec_count_next;
    logic [31:0]   time_reg, time_next;
    logic [7:0]    write_left_reg, write_left_next;
    logic [8:0]    read_left_reg, read_left_next;
    logic [2:0]    hdr_idx_reg, hdr_idx_next;
    logic [MASK_W-1:0] chan_mask_reg;

    // Parked response while the output register is occupied.
    chtr_status_t hold_status_reg;
    logic [7:0]   hold_byte_reg;
    logic         hold_valid_reg;
    logic         hold_last_reg;

    // Output register.
    logic         out_valid_reg;
    chtr_status_t out_status_reg;
    logic [7:0]   out_byte_reg;
    logic         out_bvalid_reg;
    logic         out_last_reg;
    logic [7:0]   out_recs_reg;

    // Memory ports.
    logic          wr_en;
    logic [PW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [PW-1:0] rd_addr;
    logic [7:0]    rd_data;

    // Response of the current cycle.
    logic         done_c;
    chtr_status_t res_status;
    logic [7:0]   res_byte;
    logic         res_valid;
    logic         res_last;

    logic         slot_free;
    logic         chan_on;
    chtr_status_t hdr_status;
    logic         no_fit;
    logic         can_push;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_BYTES - 1)) ? '0 : p + 1'b1;
    endfunction

    chtr_ram #(
        .DEPTH (QUEUE_BYTES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);
    assign slot_free = !out_valid_reg || rsp.ready;

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.out_byte      = out_byte_reg;
    assign rsp.byte_valid    = out_bvalid_reg;
    assign rsp.record_last   = out_last_reg;
    assign rsp.records_ready = out_recs_reg;

    // Header admission: channel first, then length, then an open record, a full
    // record counter or too little space for the whole record.
    assign chan_on = (32'(chan_reg) < NUM_CHANNELS) && chan_mask_reg[chan_reg];
    always_comb
    begin
        if (!chan_on)
        begin
            hdr_status = ST_CHAN_OFF;
        end
        else if (len_reg > 8'(MAX_LEN))
        begin
            hdr_status = ST_TOO_LONG;
        end
        else if ((write_left_reg != 8'd0) || (rec_count_reg == 8'(MAX_RECORDS)))
        begin
            hdr_status = ST_NO_SPACE;
        end
        else if ((SW'(fill_reg) + SW'(len_reg) + SW'(REC_OVERHEAD)) > SW'(QUEUE_BYTES))
        begin
            hdr_status = ST_NO_SPACE;
        end
        else
        begin
            hdr_status = ST_OK;
        end
    end

    // At a record start the stored length byte sits in rd_data during S_RDLEN.
    assign no_fit   = {1'b0, room_reg} < (13'(rd_data) + 13'd2);
    assign can_push = fill_reg < FW'(QUEUE_BYTES);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        if (state_reg != S_IDLE && done_c)
        begin
            state_next = slot_free ? S_IDLE : S_HOLD;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        state_next = S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (req_type_reg == REQ_HEADER)
                    begin
                        state_next = S_HDR;
                    end
                    else if (read_left_reg == 9'd0)
                    begin
                        state_next = S_RDLEN;
                    end
                    else
                    begin
                        state_next = S_RDBYTE;
                    end
                end
                S_RDLEN:  state_next = S_RDBYTE;
                default:  state_next = state_reg;
            endcase
        end
    end

    // Datapath, memory control and the response.
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        rec_count_next  = rec_count_reg;
        time_next       = time_reg;
        write_left_next = write_left_reg;
        read_left_next  = read_left_reg;
        hdr_idx_next    = hdr_idx_reg;
        wr_en           = 1'b0;
        wr_addr         = tail_reg;
        wr_data         = data_reg;
        rd_en           = 1'b0;
        rd_addr         = head_reg;
        done_c          = 1'b0;
        res_status      = ST_OK;
        res_byte        = 8'd0;
        res_valid       = 1'b0;
        res_last        = 1'b0;

        case (state_reg)
            S_EXEC:
            begin
                case (req_type_reg)
                    REQ_TICK:
                    begin
                        time_next = time_reg + 32'd1;
                        done_c    = 1'b1;
                    end
                    REQ_HEADER:
                    begin
                        if (hdr_status != ST_OK)
                        begin
                            res_status = hdr_status;
                            done_c     = 1'b1;
                        end
                        else
                        begin
                            write_left_next = len_reg;
                            hdr_idx_next    = HDR_CHAN;
                        end
                    end
                    REQ_PAYLOAD:
                    begin
                        if (write_left_reg != 8'd0)
                        begin
                            if (can_push)
                            begin
                                wr_en     = 1'b1;
                                tail_next = ptr_inc(tail_reg);
                                fill_next = fill_reg + 1'b1;
                            end
                            write_left_next = write_left_reg - 8'd1;
                            if (write_left_reg == 8'd1)
                            begin
                                rec_count_next = rec_count_reg + 8'd1;
                            end
                        end
                        done_c = 1'b1;
                    end
                    REQ_READ:
                    begin
                        if (rec_count_reg == 8'd0)
                        begin
                            res_status = ST_EMPTY;
                            done_c     = 1'b1;
                        end
                        else if (read_left_reg == 9'd0)
                        begin
                            // Fetch the length byte that follows the channel byte.
                            rd_en   = 1'b1;
                            rd_addr = ptr_inc(head_reg);
                        end
                        else
                        begin
                            rd_en = 1'b1;
                        end
                    end
                    REQ_FLUSH:
                    begin
                        head_next       = '0;
                        tail_next       = '0;
                        fill_next       = '0;
                        rec_count_next  = 8'd0;
                        write_left_next = 8'd0;
                        read_left_next  = 9'd0;
                        done_c          = 1'b1;
                    end
                    default:
                    begin
                        done_c = 1'b1;
                    end
                endcase
            end
            S_HDR:
            begin
                case (hdr_idx_reg)
                    HDR_CHAN: wr_data = {4'd0, chan_reg};
                    HDR_LEN:  wr_data = len_reg + 8'(LEN_BIAS);
                    HDR_TS0:  wr_data = time_reg[7:0];
                    HDR_TS1:  wr_data = time_reg[15:8];
                    HDR_TS2:  wr_data = time_reg[23:16];
                    default:  wr_data = time_reg[31:24];
                endcase
                if (can_push)
                begin
                    wr_en     = 1'b1;
                    tail_next = ptr_inc(tail_reg);
                    fill_next = fill_reg + 1'b1;
                end
                hdr_idx_next = hdr_idx_reg + 3'd1;
                if (hdr_idx_reg == HDR_TS3)
                begin
                    // An empty record is complete once its header is in.
                    if (len_reg == 8'd0)
                    begin
                        rec_count_next = rec_count_reg + 8'd1;
                    end
                    done_c = 1'b1;
                end
            end
            S_RDLEN:
            begin
                if (no_fit)
                begin
                    res_status = ST_NO_FIT;
                    done_c     = 1'b1;
                end
                else
                begin
                    read_left_next = 9'(rd_data) + 9'd2;
                    rd_en          = 1'b1;
                end
            end
            S_RDBYTE:
            begin
                res_byte       = rd_data;
                res_valid      = 1'b1;
                head_next      = ptr_inc(head_reg);
                fill_next      = fill_reg - 1'b1;
                read_left_next = read_left_reg - 9'd1;
                if (read_left_reg == 9'd1)
                begin
                    res_last       = 1'b1;
                    rec_count_next = rec_count_reg - 8'd1;
                end
                done_c = 1'b1;
            end
            S_HOLD:
            begin
                res_status = hold_status_reg;
                res_byte   = hold_byte_reg;
                res_valid  = hold_valid_reg;
                res_last   = hold_last_reg;
                done_c     = 1'b1;
            end
            default:
            begin
                done_c = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            fill_reg       <= '0;
            rec_count_reg  <= 8'd0;
            time_reg       <= 32'd0;
            write_left_reg <= 8'd0;
            read_left_reg  <= 9'd0;
            hdr_idx_reg    <= 3'd0;
            chan_mask_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            fill_reg       <= fill_next;
            rec_count_reg  <= rec_count_next;
            time_reg       <= time_next;
            write_left_reg <= write_left_next;
            read_left_reg  <= read_left_next;
            hdr_idx_reg    <= hdr_idx_next;
            if (cfg.valid)
            begin
                chan_mask_reg <= cfg.chan_mask;
            end
            if (state_reg != S_IDLE && done_c && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_type_reg <= req.req_type;
            chan_reg     <= req.channel;
            len_reg      <= req.length;
            data_reg     <= req.data_byte;
            room_reg     <= req.room;
        end
        if (state_reg != S_IDLE && done_c)
        begin
            if (slot_free)
            begin
                out_status_reg <= res_status;
                out_byte_reg   <= res_byte;
                out_bvalid_reg <= res_valid;
                out_last_reg   <= res_last;
                out_recs_reg   <= rec_count_next;
            end
            else
            begin
                hold_status_reg <= res_status;
                hold_byte_reg   <= res_byte;
                hold_valid_reg  <= res_valid;
                hold_last_reg   <= res_last;
            end
        end
    end

endmodule

`default_nettype wire

### tb/sv/trace_check_pkg.sv
// Scoreboard for the channel trace record FIFO testbench: a predictor of the queue
// and the store of responses it expects. Depends on chtr_pkg from the RTL.
`timescale 1ns / 1ps

package trace_check_pkg;
    import chtr_pkg::*;

    // Request type codes that the block ignores.
    localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

    typedef struct {
        logic [2:0] status;
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       record_last;
        logic [7:0] records_ready;
    } trace_reply_t;

    class trace_record_checker;
        bit [7:0]     shadow_mem [QUEUE_BYTES_DEF];
        int           rd_ptr;
        int           wr_ptr;
        int           fill;
        int           complete_records;
        bit [31:0]    stamp;
        int           payload_left;
        int           bytes_left_in_read;
        bit [15:0]    chan_mask;
        trace_reply_t pending_replies [$];
        int           errors;

        function new();
            clear_queue();
            stamp     = '0;
            chan_mask = '0;
            errors    = 0;
        endfunction

        function void clear_queue();
            rd_ptr             = 0;
            wr_ptr             = 0;
            fill               = 0;
            complete_records   = 0;
            payload_left       = 0;
            bytes_left_in_read = 0;
        endfunction

        function void set_mask(logic [15:0] mask);
            chan_mask = mask;
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        function void push(bit [7:0] value);
            shadow_mem[wr_ptr] = value;
            wr_ptr = (wr_ptr + 1) % QUEUE_BYTES_DEF;
            fill++;
        endfunction

        // Works out the response to one accepted request and updates the shadow state.
        function void note_request(logic [2:0] kind, logic [3:0] chan, logic [7:0] len,
                                   logic [7:0] data, logic [11:0] room);
            trace_reply_t r;
            int           stored;
            r = '{ST_OK, 8'h00, 1'b0, 1'b0, 8'h00};
            case (kind)
                REQ_TICK: stamp = stamp + 32'd1;
                REQ_HEADER:
                begin
                    if (!chan_mask[chan])
                        r.status = ST_CHAN_OFF;
                    else if (len > MAX_LEN)
                        r.status = ST_TOO_LONG;
                    else if (payload_left != 0 || complete_records >= MAX_RECORDS)
                        r.status = ST_NO_SPACE;
                    else if (fill + int'(len) + REC_OVERHEAD > QUEUE_BYTES_DEF)
                        r.status = ST_NO_SPACE;
                    else
                    begin
                        push({4'h0, chan});
                        push(8'(len + LEN_BIAS));
                        for (int k = 0; k < 4; k++)
                            push(stamp[8 * k +: 8]);
                        payload_left = len;
                        if (len == 0)
                            complete_records++;
                    end
                end
                REQ_PAYLOAD:
                begin
                    if (payload_left != 0)
                    begin
                        push(data);
                        payload_left--;
                        if (payload_left == 0)
                            complete_records++;
                    end
                end
                REQ_READ:
                begin
                    if (complete_records == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        stored = shadow_mem[(rd_ptr + 1) % QUEUE_BYTES_DEF];
                        if (bytes_left_in_read == 0 && int'(room) < stored + 2)
                            r.status = ST_NO_FIT;
                        else
                        begin
                            if (bytes_left_in_read == 0)
                                bytes_left_in_read = stored + 2;
                            r.out_byte   = shadow_mem[rd_ptr];
                            r.byte_valid = 1'b1;
                            rd_ptr = (rd_ptr + 1) % QUEUE_BYTES_DEF;
                            fill--;
                            bytes_left_in_read--;
                            if (bytes_left_in_read == 0)
                            begin
                                r.record_last = 1'b1;
                                complete_records--;
                            end
                        end
                    end
                end
                REQ_FLUSH: clear_queue();
                default: ;
            endcase
            r.records_ready = 8'(complete_records);
            pending_replies.push_back(r);
        endfunction

        function void check_response(trace_reply_t got);
            trace_reply_t want;
            if (pending_replies.size() == 0)
            begin
                $error("response with no request outstanding: status %0d, byte 0x%02h",
                       got.status, got.out_byte);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.byte_valid !== want.byte_valid)
            begin
                $error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
                errors++;
            end
            if (got.record_last !== want.record_last)
            begin
                $error("record_last: expected %0b, got %0b", want.record_last, got.record_last);
                errors++;
            end
            if (got.records_ready !== want.records_ready)
            begin
                $error("records_ready: expected %0d, got %0d",
                       want.records_ready, got.records_ready);
                errors++;
            end
        endfunction
    endclass

endpackage

### tb/sv/testbench.sv
// Top level of the channel trace record FIFO testbench: clock, reset, request drivers,
// monitors and the stimulus. Depends on chtr_pkg, the three RTL channel interfaces,
// trace_check_pkg and the block itself.
`timescale 1ns / 1ps

module testbench;
    import chtr_pkg::*;
    import trace_check_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 4;
    // A request costs at most the longest sender gap and the longest sink stall stacked
    // on an accepted header. Even with every phase overrunning by a full record of
    // interleaved requests the run stays several times under this limit.
    localparam int CYCLE_LIMIT   = 5_000_000;
    // An accepted header is the longest request; this leaves ample margin
    // for any stray response to show up after the last expected one.
    localparam int SETTLE_CYCLES = 20;
    localparam int NUM_PHASES    = 7;

    logic clk = 1'b0;
    logic rst_n;

    chtr_cfg_if cfg ();
    chtr_req_if req ();
    chtr_rsp_if rsp ();

    trace_record_checker record_chk = new();

    int requests_sent = 0;
    int cycle_count   = 0;
    bit sender_gaps_on = 1'b0;
    bit sink_stalls_on = 1'b0;

    channel_trace_record_fifo dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Gap length in cycles. With probability pct there is a gap at all; most gaps are
    // short, a few are long.
    function automatic int pick_gap(int pct);
        int r;
        if ($urandom_range(0, 99) >= pct)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Most records go to an enabled channel so that they actually reach the queue.
    // The rest pick any channel and may be refused as disabled.
    function automatic logic [3:0] pick_channel();
        logic [3:0] c;
        c = 4'($urandom_range(0, 15));
        if (record_chk.chan_mask != 16'h0000 && $urandom_range(0, 99) < 85)
            while (!record_chk.chan_mask[c])
                c = c + 4'd1;
        return c;
    endfunction

    // The reader's room is usually generous. Small values hit the no-fit refusal at a
    // record start, and the full random range toggles every bit of the field.
    function automatic logic [11:0] pick_room();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 12'hFFF;
        if (r < 85)
            return 12'($urandom_range(0, 4095));
        return 12'($urandom_range(0, 260));
    endfunction

    // Drives one request. Fields change at the falling edge and the handshake is seen
    // at the rising edge. Valid stays high across back-to-back requests.
    task automatic send_req(logic [2:0] kind, logic [3:0] chan, logic [7:0] len,
                            logic [7:0] data, logic [11:0] room);
        int gap;
        gap = sender_gaps_on ? pick_gap(35) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.req_type  = kind;
        req.channel   = chan;
        req.length    = len;
        req.data_byte = data;
        req.room      = room;
        req.valid     = 1'b1;
        do
            @(posedge clk);
        while (req.ready !== 1'b1);
        requests_sent++;
    endtask

    // A request of the given kind with every other field random.
    task automatic send_kind(logic [2:0] kind);
        send_req(kind, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), pick_room());
    endtask

    // Drops valid and holds off until every expected response has come back.
    task automatic wait_idle();
        @(negedge clk);
        req.valid = 1'b0;
        while (record_chk.pending() != 0)
            @(posedge clk);
    endtask

    // The mask is only written while the block is idle.
    task automatic write_mask(logic [15:0] mask);
        wait_idle();
        @(negedge clk);
        cfg.chan_mask = mask;
        cfg.valid     = 1'b1;
        do
            @(posedge clk);
        while (cfg.ready !== 1'b1);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    // One well-formed record: a header followed by its payload bytes. Ticks and reads
    // of older records are mixed in, and now and then a second header, which is refused
    // while the record is open, or a flush, which breaks the record.
    task automatic send_record(int long_pct, int read_pct);
        logic [7:0] len;
        int         r;
        int         i;
        r = $urandom_range(0, 99);
        if (r < long_pct)
            len = 8'($urandom_range(65, MAX_LEN));
        else if (r < long_pct + 20)
            len = 8'($urandom_range(13, 64));
        else
            len = 8'($urandom_range(0, 12));
        send_req(REQ_HEADER, pick_channel(), len, 8'($urandom_range(0, 255)), pick_room());
        for (i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 199);
            if (r < 10)
                send_kind(REQ_TICK);
            else if (r < 10 + read_pct / 2)
                send_kind(REQ_READ);
            else if (r == 198)
                send_kind(REQ_HEADER);
            else if (r == 199)
                send_kind(REQ_FLUSH);
            send_kind(REQ_PAYLOAD);
        end
    endtask

    task automatic random_step(int long_pct, int read_pct);
        int r;
        int n;
        // Once in a while the sender waits for the block to drain completely.
        if ($urandom_range(0, 99) < 2)
            wait_idle();
        r = $urandom_range(0, 99);
        if (r < 55)
            send_record(long_pct, read_pct);
        else if (r < 55 + read_pct)
        begin
            n = $urandom_range(1, 8);
            repeat (n) send_kind(REQ_READ);
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                send_kind(REQ_TICK);
            else if (r < 75)
                send_kind(REQ_PAYLOAD);
            else if (r < 78)
                send_kind(REQ_FLUSH);
            else if (r < 88)
                send_kind(3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST)));
            else
                send_kind(REQ_HEADER);
        end
    endtask

    // The response sink stalls at random. With stalls off it is always ready.
    initial
    begin
        int stall;
        forever
        begin
            stall = sink_stalls_on ? pick_gap(25) : 0;
            rsp.ready = (stall == 0);
            repeat ((stall == 0) ? 1 : stall) @(negedge clk);
        end
    end

    // Monitor: mask writes, accepted requests and accepted responses, all seen at the
    // rising edge. Requests are noted before responses are checked.
    always @(posedge clk)
    begin
        trace_reply_t seen;
        if (rst_n)
        begin
            if (cfg.valid === 1'b1 && cfg.ready === 1'b1)
                record_chk.set_mask(cfg.chan_mask);
            if (req.valid === 1'b1 && req.ready === 1'b1)
                record_chk.note_request(req.req_type, req.channel, req.length,
                                        req.data_byte, req.room);
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                seen = '{rsp.status, rsp.out_byte, rsp.byte_valid, rsp.record_last,
                         rsp.records_ready};
                record_chk.check_response(seen);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] phase_mask  [NUM_PHASES];
        int          phase_items [NUM_PHASES];
        int          phase_long  [NUM_PHASES];
        int          phase_read  [NUM_PHASES];
        int          p;
        int          target;

        req.valid     = 1'b0;
        req.req_type  = REQ_TICK;
        req.channel   = '0;
        req.length    = '0;
        req.data_byte = '0;
        req.room      = '0;
        cfg.valid     = 1'b0;
        cfg.chan_mask = '0;
        rst_n         = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. The mask is still at its reset value of zero, so the first
        // header is refused as a disabled channel, and a read finds nothing.
        send_req(REQ_READ,   4'd0, 8'd0, 8'h00, 12'hFFF);
        send_req(REQ_HEADER, 4'd3, 8'd5, 8'h00, 12'h000);
        write_mask(16'hFFFF);
        send_req(REQ_TICK, 4'd0, 8'd0, 8'h00, 12'h000);
        send_req(REQ_TICK, 4'd0, 8'd0, 8'h00, 12'h000);
        // A zero-length record is complete as soon as its header is in.
        send_req(REQ_HEADER, 4'd0, 8'd0, 8'h00, 12'h000);
        // Lengths just over the limit and at the top of the field are refused.
        send_req(REQ_HEADER, 4'd15, 8'd252, 8'h00, 12'h000);
        send_req(REQ_HEADER, 4'd15, 8'd255, 8'h00, 12'h000);
        send_req(REQ_HEADER, 4'd9, 8'd2, 8'h00, 12'h000);
        // A second header while a record is open is refused and the open one goes on.
        send_req(REQ_HEADER, 4'd1, 8'd1, 8'h00, 12'h000);
        send_req(REQ_PAYLOAD, 4'd0, 8'd0, 8'h00, 12'h000);
        send_req(REQ_PAYLOAD, 4'd0, 8'd0, 8'hFF, 12'h000);
        // A payload byte with no open record is dropped.
        send_req(REQ_PAYLOAD, 4'd0, 8'd0, 8'hA5, 12'h000);
        // The six-byte record does not fit in a room of zero or of five.
        send_req(REQ_READ, 4'd0, 8'd0, 8'h00, 12'd0);
        send_req(REQ_READ, 4'd0, 8'd0, 8'h00, 12'd5);
        // A room of exactly six fits; inside the record the room is not checked.
        send_req(REQ_READ, 4'd0, 8'd0, 8'h00, 12'd6);
        repeat (5) send_req(REQ_READ, 4'd0, 8'd0, 8'h00, 12'd0);
        send_req(REQ_SPARE_FIRST, 4'd0, 8'd0, 8'h00, 12'h000);
        send_req(REQ_SPARE_LAST,  4'd0, 8'd0, 8'h00, 12'h000);
        send_req(REQ_READ, 4'd0, 8'd0, 8'h00, 12'hFFF);
        // A flush in the middle of reading a record empties the queue.
        send_req(REQ_FLUSH, 4'd0, 8'd0, 8'h00, 12'h000);
        send_req(REQ_READ,  4'd0, 8'd0, 8'h00, 12'hFFF);

        // Random part in phases. The first phase rarely reads, so the queue fills up and
        // headers are refused for lack of space; a later phase reads heavily and drains
        // it. The single-channel masks sit at both ends of the field, and one phase has
        // every channel off.
        phase_mask  = '{16'hFFFF, 16'h0000, 16'h0001, 16'h8000, 16'h0000, 16'hFFFF, 16'h0000};
        phase_items = '{320, 300, 200, 200, 60, 480, 300};
        phase_long  = '{40, 10, 15, 15, 10, 10, 20};
        phase_read  = '{3, 25, 20, 20, 20, 35, 15};
        phase_mask[1] = 16'($urandom_range(0, 65535));
        phase_mask[6] = 16'($urandom_range(0, 65535));

        for (p = 0; p < NUM_PHASES; p++)
        begin
            write_mask(phase_mask[p]);
            // Phase 1 runs with no idling on either side at all.
            sender_gaps_on = (p != 1);
            sink_stalls_on = (p != 1 && p != 4);
            target = requests_sent + phase_items[p];
            while (requests_sent < target)
                random_step(phase_long[p], phase_read[p]);
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (record_chk.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
